>>> hw/rtl/mcm_pkg.sv
// Shared types and constants for the 4x4 column matrix multiply unit.
// Holds the command and response structures used by the front, back and top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mcm_pkg;

   localparam int DIM = 4;
   localparam int WORD_W = 32;
   localparam int COL_W = 2;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int CMD_DEPTH_DEFAULT = 2;
   localparam int RSP_DEPTH_DEFAULT = 4;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_MULTIPLY = 1'b1;

   typedef logic [DIM-1:0][WORD_W-1:0] column_type;

   typedef struct packed {
      logic mode;
      logic [COL_W-1:0] column;
      column_type elem;
   } cmd_type;

   typedef struct packed {
      logic [COL_W-1:0] column;
      column_type prod;
      logic saturated;
   } rsp_type;

endpackage
`default_nettype wire

>>> hw/rtl/mcm_fifo.sv
// Generic register-based first-in first-out queue with a registered data store.
// Used for the command queue and the response queue. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mcm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input wire logic [WIDTH-1:0] push_data,
   output logic full,
   input wire logic pop,
   output logic [WIDTH-1:0] pop_data,
   output logic empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign count = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/mcm_front.sv
// Front end: takes request beats, packs them into commands and queues them.
// Depends on mcm_pkg and mcm_fifo.
`timescale 1ns / 1ps
`default_nettype none
module mcm_front #(
   parameter int CMD_DEPTH = mcm_pkg::CMD_DEPTH_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_push,
   output logic req_full,
   input wire logic req_mode,
   input wire logic [mcm_pkg::COL_W-1:0] req_column,
   input wire mcm_pkg::column_type req_elem,
   output logic cmd_valid,
   output mcm_pkg::cmd_type cmd,
   input wire logic cmd_pop
);

   mcm_pkg::cmd_type cmd_in;
   logic [$bits(mcm_pkg::cmd_type)-1:0] cmd_raw;
   logic cmd_empty;

   always_comb begin
      cmd_in.mode = (req_mode == mcm_pkg::MODE_MULTIPLY) ? mcm_pkg::MODE_MULTIPLY
                                                          : mcm_pkg::MODE_LOAD;
      cmd_in.column = req_column;
      cmd_in.elem = req_elem;
   end

   mcm_fifo #(
      .WIDTH($bits(mcm_pkg::cmd_type)),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_fifo (
      .clock(clock),
      .reset(reset),
      .push(req_push),
      .push_data(cmd_in),
      .full(req_full),
      .pop(cmd_pop),
      .pop_data(cmd_raw),
      .empty(cmd_empty),
      .count()
   );

   assign cmd_valid = !cmd_empty;
   assign cmd = mcm_pkg::cmd_type'(cmd_raw);

endmodule
`default_nettype wire

>>> hw/rtl/mcm_back.sv
// Back end: holds matrix A, executes loads and runs the two-stage multiply pipeline.
// Stage one forms sixteen scaled products, stage two sums and saturates them.
// Depends on mcm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mcm_back #(
   parameter int FRAC_BITS = mcm_pkg::FRAC_BITS_DEFAULT,
   parameter int RSP_DEPTH = mcm_pkg::RSP_DEPTH_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic cmd_valid,
   input wire mcm_pkg::cmd_type cmd,
   output logic cmd_pop,
   input wire logic [$clog2(RSP_DEPTH+1)-1:0] rsp_count,
   output logic rsp_push,
   output mcm_pkg::rsp_type rsp
);

   localparam int DIM = mcm_pkg::DIM;
   localparam int WORD_W = mcm_pkg::WORD_W;
   localparam int FULL_W = 2 * WORD_W;
   localparam int PROD_W = FULL_W - FRAC_BITS;
   localparam int SUM_W = PROD_W + 2;
   localparam int CW = $clog2(RSP_DEPTH + 1) + 1;

   logic [WORD_W-1:0] mat_ff [DIM][DIM];
   logic signed [PROD_W-1:0] prod_ff [DIM][DIM];
   logic signed [PROD_W-1:0] prod_in [DIM][DIM];
   logic s1_valid_ff;
   logic [mcm_pkg::COL_W-1:0] s1_column_ff;
   logic room;
   logic do_load, do_mult;
   logic [DIM-1:0] clip;

   assign room = (CW'(rsp_count) + CW'(s1_valid_ff)) < CW'(RSP_DEPTH);
   assign cmd_pop = cmd_valid && ((cmd.mode == mcm_pkg::MODE_LOAD) || room);
   assign do_load = cmd_pop && (cmd.mode == mcm_pkg::MODE_LOAD);
   assign do_mult = cmd_pop && (cmd.mode == mcm_pkg::MODE_MULTIPLY);

   always_comb begin
      logic signed [FULL_W-1:0] full_prod;
      logic signed [FULL_W-1:0] scaled;
      for (int r = 0; r < DIM; r++) begin
         for (int k = 0; k < DIM; k++) begin
            full_prod = $signed(mat_ff[k][r]) * $signed(cmd.elem[k]);
            scaled = full_prod >>> FRAC_BITS;
            prod_in[r][k] = scaled[PROD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < DIM; c++) begin
            for (int r = 0; r < DIM; r++) begin
               mat_ff[c][r] <= '0;
            end
         end
         s1_valid_ff <= 1'b0;
      end else begin
         if (do_load) begin
            for (int r = 0; r < DIM; r++) begin
               mat_ff[cmd.column][r] <= cmd.elem[r];
            end
         end
         s1_valid_ff <= do_mult;
      end
   end

   always_ff @(posedge clock) begin
      if (do_mult) begin
         prod_ff <= prod_in;
         s1_column_ff <= cmd.column;
      end
   end

   always_comb begin
      logic signed [SUM_W-1:0] sum;
      logic [SUM_W-WORD_W:0] top;
      rsp.column = s1_column_ff;
      for (int r = 0; r < DIM; r++) begin
         sum = SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1])
             + SUM_W'(prod_ff[r][2]) + SUM_W'(prod_ff[r][3]);
         top = sum[SUM_W-1:WORD_W-1];
         clip[r] = !((&top) || !(|top));
         if (!clip[r]) begin
            rsp.prod[r] = sum[WORD_W-1:0];
         end else if (sum[SUM_W-1]) begin
            rsp.prod[r] = {1'b1, {(WORD_W-1){1'b0}}};
         end else begin
            rsp.prod[r] = {1'b0, {(WORD_W-1){1'b1}}};
         end
      end
      rsp.saturated = |clip;
   end

   assign rsp_push = s1_valid_ff;

endmodule
`default_nettype wire

>>> hw/rtl/matrix4x4_column_multiply_unit.sv
// Top level of the 4x4 column-major fixed-point matrix multiply unit.
// Connects the front command queue, the back execution pipeline and the response queue.
// Depends on mcm_pkg, mcm_fifo, mcm_front and mcm_back.
//
// Usage: request beats enter through a queue interface (req_push, req_full). A beat with
// req_mode clear writes column req_column of matrix A and gives no response. A beat with
// req_mode set carries column j of B and gives column j of A x B, signed Q16.16, each
// element saturated to 32 bits, with rsp_saturated set if any element was clipped.
// Responses leave through a queue interface (rsp_empty, rsp_pop) in request order.
// Throughput is one beat per cycle, set by the sixteen parallel multipliers of the back
// stage, while the response queue has room. An accepted multiply beat reaches the ports
// through the command queue, the product register and the response queue, in that order.
// A load takes effect for every multiply beat accepted after it. Reset empties both
// queues and clears matrix A to zero. When the receiver stops popping, the back stage
// holds multiply commands once the response queue and the product register fill, then
// the command queue fills and req_full rises.
`timescale 1ns / 1ps
`default_nettype none
module matrix4x4_column_multiply_unit #(
   parameter int FRAC_BITS = mcm_pkg::FRAC_BITS_DEFAULT,
   parameter int CMD_DEPTH = mcm_pkg::CMD_DEPTH_DEFAULT,
   parameter int RSP_DEPTH = mcm_pkg::RSP_DEPTH_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_push,
   output logic req_full,
   input wire logic req_mode,
   input wire logic [mcm_pkg::COL_W-1:0] req_column,
   input wire logic signed [mcm_pkg::WORD_W-1:0] req_elem0,
   input wire logic signed [mcm_pkg::WORD_W-1:0] req_elem1,
   input wire logic signed [mcm_pkg::WORD_W-1:0] req_elem2,
   input wire logic signed [mcm_pkg::WORD_W-1:0] req_elem3,
   output logic rsp_empty,
   input wire logic rsp_pop,
   output logic [mcm_pkg::COL_W-1:0] rsp_out_column,
   output logic signed [mcm_pkg::WORD_W-1:0] rsp_prod0,
   output logic signed [mcm_pkg::WORD_W-1:0] rsp_prod1,
   output logic signed [mcm_pkg::WORD_W-1:0] rsp_prod2,
   output logic signed [mcm_pkg::WORD_W-1:0] rsp_prod3,
   output logic rsp_saturated
);

   mcm_pkg::column_type req_elem;
   mcm_pkg::cmd_type cmd;
   mcm_pkg::rsp_type rsp_in;
   mcm_pkg::rsp_type rsp_out;
   logic [$bits(mcm_pkg::rsp_type)-1:0] rsp_raw;
   logic cmd_valid, cmd_pop, rsp_push, rsp_full;
   logic [$clog2(RSP_DEPTH+1)-1:0] rsp_count;

   assign req_elem[0] = req_elem0;
   assign req_elem[1] = req_elem1;
   assign req_elem[2] = req_elem2;
   assign req_elem[3] = req_elem3;

   mcm_front #(
      .CMD_DEPTH(CMD_DEPTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_mode(req_mode),
      .req_column(req_column),
      .req_elem(req_elem),
      .cmd_valid(cmd_valid),
      .cmd(cmd),
      .cmd_pop(cmd_pop)
   );

   mcm_back #(
      .FRAC_BITS(FRAC_BITS),
      .RSP_DEPTH(RSP_DEPTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cmd_valid(cmd_valid),
      .cmd(cmd),
      .cmd_pop(cmd_pop),
      .rsp_count(rsp_count),
      .rsp_push(rsp_push),
      .rsp(rsp_in)
   );

   mcm_fifo #(
      .WIDTH($bits(mcm_pkg::rsp_type)),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_fifo (
      .clock(clock),
      .reset(reset),
      .push(rsp_push && !rsp_full),
      .push_data(rsp_in),
      .full(rsp_full),
      .pop(rsp_pop),
      .pop_data(rsp_raw),
      .empty(rsp_empty),
      .count(rsp_count)
   );

   assign rsp_out = mcm_pkg::rsp_type'(rsp_raw);
   assign rsp_out_column = rsp_out.column;
   assign rsp_prod0 = rsp_out.prod[0];
   assign rsp_prod1 = rsp_out.prod[1];
   assign rsp_prod2 = rsp_out.prod[2];
   assign rsp_prod3 = rsp_out.prod[3];
   assign rsp_saturated = rsp_out.saturated;

endmodule
`default_nettype wire
